// ===== src/bsc_pkg.sv =====
// Shared widths, register indexes, unit status type and shift helpers.
package bsc_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned RawW    = 20;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 64;

	localparam logic [CfgIdxW-1:0] REG_TEMP_COEFFS = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESS_LOW   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_PRESS_NINE  = 2'd3;

	localparam logic [63:0] TEMP_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_FULL  = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
		return $signed(x) >>> s;
	endfunction

endpackage

// ===== src/bsc_if.sv =====
// Handshake channel interfaces: sample input, result output and register writes.
interface bsc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [bsc_pkg::RawW-1:0]    raw_sample;
	modport source (output valid, mode, raw_sample, input ready);
	modport sink   (input valid, mode, raw_sample, output ready);
endinterface

interface bsc_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_q24_8;
	modport source (output valid, kind, temperature_centi, pressure_q24_8, input ready);
	modport sink   (input valid, kind, temperature_centi, pressure_q24_8, output ready);
endinterface

interface bsc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bsc_pkg::CfgIdxW-1:0]   index;
	logic [bsc_pkg::CfgW-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bsc_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle, product modulo 2^64.
module bsc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bsc_pkg::WordW-1:0]     a,
	input  logic [bsc_pkg::WordW-1:0]     b,
	output logic [bsc_pkg::WordW-1:0]     product,
	output bsc_pkg::unit_stat_t           stat
);
	logic [bsc_pkg::WordW-1:0] acc_q, a_q, b_q;
	logic                      busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[bsc_pkg::WordW-2:0], 1'b0};
			b_q <= {1'b0, b_q[bsc_pkg::WordW-1:1]};
		end
	end

	// Finishes as soon as the remaining multiplier bits are all zero.
	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = busy_q && b_q == '0;
endmodule

// ===== src/bsc_div.sv =====
// Serial restoring divider for unsigned 64-bit magnitudes, one quotient bit per cycle.
module bsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bsc_pkg::WordW-1:0]     dividend,
	input  logic [bsc_pkg::WordW-1:0]     divisor,
	output logic [bsc_pkg::WordW-1:0]     quotient,
	output bsc_pkg::unit_stat_t           stat
);
	localparam int unsigned CntW = $clog2(bsc_pkg::WordW + 1);

	logic [bsc_pkg::WordW-1:0] rem_q, quo_q, den_q;
	logic [CntW-1:0]           cnt_q;
	logic                      busy_q;
	logic [bsc_pkg::WordW:0]   trial;
	logic                      last;

	assign trial = {rem_q, quo_q[bsc_pkg::WordW-1]} - {1'b0, den_q};
	assign last  = cnt_q == CntW'(bsc_pkg::WordW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q && !last) begin
			if (!trial[bsc_pkg::WordW]) begin
				rem_q <= trial[bsc_pkg::WordW-1:0];
				quo_q <= {quo_q[bsc_pkg::WordW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[bsc_pkg::WordW-2:0], quo_q[bsc_pkg::WordW-1]};
				quo_q <= {quo_q[bsc_pkg::WordW-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = busy_q && last;
endmodule

// ===== src/baro_sensor_compensation.sv =====
// Barometric compensation block: sequencer around a serial multiplier and divider.
// Each item is a raw 20-bit converter reading tagged as temperature or pressure, and
// gives exactly one result. A temperature item runs three serial multiplications; a
// pressure item runs ten multiplications and one 64-bit division, or only six
// multiplications when the P1 divisor is zero. The run time is set by the shared
// shift-add multiplier, which retires one multiplier bit per cycle and stops early
// once the remaining bits are zero, and by the divider, which retires one quotient
// bit per cycle for all 64 bits. One item is worked on at a time; a new item is taken
// once the previous result sits in the output register, even if it is still waiting
// there. Configuration writes are taken in any cycle and must only be issued while
// the block is idle. A pressure item uses the fine temperature left by the latest
// temperature item, or zero after reset.
module baro_sensor_compensation (
	input  logic      clk,
	input  logic      arst_n,
	bsc_in_if.sink    in_ch,
	bsc_out_if.source out_ch,
	bsc_cfg_if.sink   cfg
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_T_A  = 4'd1;
	localparam logic [3:0] S_T_B  = 4'd2;
	localparam logic [3:0] S_T_C  = 4'd3;
	localparam logic [3:0] S_P_XX = 4'd4;
	localparam logic [3:0] S_P_Y  = 4'd5;
	localparam logic [3:0] S_P_5  = 4'd6;
	localparam logic [3:0] S_P_3  = 4'd7;
	localparam logic [3:0] S_P_2  = 4'd8;
	localparam logic [3:0] S_P_1  = 4'd9;
	localparam logic [3:0] S_P_N  = 4'd10;
	localparam logic [3:0] S_P_D  = 4'd11;
	localparam logic [3:0] S_P_H  = 4'd12;
	localparam logic [3:0] S_P_Q  = 4'd13;
	localparam logic [3:0] S_P_8  = 4'd14;
	localparam logic [3:0] S_OUT  = 4'd15;

	// Calibration registers.
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_low_q, press_high_q;
	logic [15:0] press_nine_q;

	// Sequencer state and working registers.
	logic [3:0]                  st_q;
	logic                        issued_q;
	logic [bsc_pkg::RawW-1:0]    adc_q;
	logic [31:0]                 ft_q;
	logic [63:0]                 x_q, xx_q, y_q, w_q;
	logic                        res_kind_q;
	logic [31:0]                 res_temp_q, res_press_q;
	logic                        out_valid_q, out_kind_q;
	logic [31:0]                 out_temp_q, out_press_q;

	logic [63:0]         mul_a, mul_b, mul_p, div_q;
	logic                mul_start, div_start, uses_mul;
	bsc_pkg::unit_stat_t mul_stat, div_stat;

	// Coefficient slices.
	logic [15:0] t1;
	logic [31:0] t2, t3, ta, tb;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] ft_next;
	logic [63:0] x_div, div_num, div_den, x_first;
	logic        n_neg, d_neg;

	assign t1 = temp_coeffs_q[15:0];
	assign t2 = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
	assign t3 = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
	assign p1 = {48'd0, press_low_q[15:0]};
	assign p2 = bsc_pkg::sx16(press_low_q[31:16]);
	assign p3 = bsc_pkg::sx16(press_low_q[47:32]);
	assign p4 = bsc_pkg::sx16(press_low_q[63:48]);
	assign p5 = bsc_pkg::sx16(press_high_q[15:0]);
	assign p6 = bsc_pkg::sx16(press_high_q[31:16]);
	assign p7 = bsc_pkg::sx16(press_high_q[47:32]);
	assign p8 = bsc_pkg::sx16(press_high_q[63:48]);
	assign p9 = bsc_pkg::sx16(press_nine_q);

	// Temperature operands in 32-bit wrapping arithmetic.
	assign ta = {15'd0, adc_q[19:3]} - {15'd0, t1, 1'b0};
	assign tb = {16'd0, adc_q[19:4]} - {16'd0, t1};

	// Fine temperature as soon as the third product is in.
	assign ft_next = w_q[31:0] + bsc_pkg::asr32(mul_p[31:0], 14);

	// Offset fine temperature that opens the pressure path.
	assign x_first = {{32{ft_q[31]}}, ft_q} - bsc_pkg::TEMP_OFFSET;

	// Divisor produced by the P1 product.
	assign x_div = bsc_pkg::asr64(mul_p, 33);

	// Signed division by magnitudes; the sign is restored afterwards.
	assign n_neg   = w_q[63];
	assign d_neg   = x_q[63];
	assign div_num = n_neg ? (64'd0 - w_q) : w_q;
	assign div_den = d_neg ? (64'd0 - x_q) : x_q;

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		uses_mul = 1'b1;
		case (st_q)
			S_T_A: begin
				mul_a = {32'd0, ta};
				mul_b = {32'd0, t2};
			end
			S_T_B: begin
				mul_a = {32'd0, tb};
				mul_b = {32'd0, tb};
			end
			S_T_C: begin
				mul_a = {32'd0, y_q[31:0]};
				mul_b = {32'd0, t3};
			end
			S_P_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			S_P_Y: begin
				mul_a = xx_q;
				mul_b = p6;
			end
			S_P_5: begin
				mul_a = x_q;
				mul_b = p5;
			end
			S_P_3: begin
				mul_a = xx_q;
				mul_b = p3;
			end
			S_P_2: begin
				mul_a = x_q;
				mul_b = p2;
			end
			S_P_1: begin
				mul_a = (64'd1 << 47) + w_q;
				mul_b = p1;
			end
			S_P_N: begin
				mul_a = ((bsc_pkg::PRESS_FULL - {44'd0, adc_q}) << 31) - y_q;
				mul_b = bsc_pkg::PRESS_SCALE;
			end
			S_P_H: begin
				mul_a = bsc_pkg::asr64(y_q, 13);
				mul_b = bsc_pkg::asr64(y_q, 13);
			end
			S_P_Q: begin
				mul_a = xx_q;
				mul_b = p9;
			end
			S_P_8: begin
				mul_a = p8;
				mul_b = y_q;
			end
			default: begin
				uses_mul = 1'b0;
			end
		endcase
	end

	assign mul_start = uses_mul && !issued_q;
	assign div_start = st_q == S_P_D && !issued_q;

	bsc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p),
		.stat    (mul_stat)
	);

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_q),
		.stat     (div_stat)
	);

	// Configuration writes are always accepted.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_low_q   <= '0;
			press_high_q  <= '0;
			press_nine_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bsc_pkg::REG_TEMP_COEFFS: temp_coeffs_q <= cfg.data[47:0];
				bsc_pkg::REG_PRESS_LOW:   press_low_q   <= cfg.data;
				bsc_pkg::REG_PRESS_HIGH:  press_high_q  <= cfg.data;
				bsc_pkg::REG_PRESS_NINE:  press_nine_q  <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = st_q == S_IDLE;

	// Control state: sequencer, issue flag, fine temperature, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			issued_q    <= 1'b0;
			ft_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one leaving in the same cycle.
			if (st_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end
			case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						st_q <= in_ch.mode ? S_P_XX : S_T_A;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						st_q <= S_IDLE;
					end
				end
				S_P_D: begin
					if (div_stat.done) begin
						issued_q <= 1'b0;
						st_q     <= S_P_H;
					end
				end
				default: begin
					if (mul_stat.done) begin
						issued_q <= 1'b0;
						case (st_q)
							S_T_C: begin
								ft_q <= ft_next;
								st_q <= S_OUT;
							end
							S_P_1: st_q <= (x_div == '0) ? S_OUT : S_P_N;
							S_P_8: st_q <= S_OUT;
							default: st_q <= st_q + 4'd1;
						endcase
					end
				end
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				adc_q       <= in_ch.raw_sample;
				res_kind_q  <= in_ch.mode;
				x_q         <= x_first;
				res_temp_q  <= '0;
				res_press_q <= '0;
			end
			S_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_kind_q  <= res_kind_q;
					out_temp_q  <= res_temp_q;
					out_press_q <= res_press_q;
				end
			end
			S_P_D: begin
				if (div_stat.done) begin
					y_q <= (n_neg != d_neg) ? (64'd0 - div_q) : div_q;
				end
			end
			default: begin
				if (mul_stat.done) begin
					case (st_q)
						S_T_A: w_q[31:0] <= bsc_pkg::asr32(mul_p[31:0], 11);
						S_T_B: y_q[31:0] <= bsc_pkg::asr32(mul_p[31:0], 12);
						S_T_C: begin
							// Temperature = (fine * 5 + 128) >> 8.
							res_temp_q <= bsc_pkg::asr32(
								ft_next + {ft_next[29:0], 2'b00} + 32'd128, 8);
						end
						S_P_XX: xx_q <= mul_p;
						S_P_Y:  y_q  <= mul_p;
						S_P_5:  y_q  <= y_q + (mul_p << 17) + (p4 << 35);
						S_P_3:  w_q  <= bsc_pkg::asr64(mul_p, 8);
						S_P_2:  w_q  <= w_q + (mul_p << 12);
						S_P_1:  x_q  <= x_div;
						S_P_N:  w_q  <= mul_p;
						S_P_H:  xx_q <= mul_p;
						S_P_Q:  w_q  <= bsc_pkg::asr64(mul_p, 25);
						S_P_8: begin
							res_press_q <= 32'(bsc_pkg::asr64(
								y_q + w_q + bsc_pkg::asr64(mul_p, 19), 8) + (p7 << 4));
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.kind              = out_kind_q;
	assign out_ch.temperature_centi = out_temp_q;
	assign out_ch.pressure_q24_8    = out_press_q;

	// The multiplier is never started while it is still working.
	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> st_q == S_P_D)
		else $error("divider finished outside its step");

	// An accepted item always moves the sequencer out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> st_q != S_IDLE)
		else $error("accepted item left the sequencer idle");

endmodule
